// ===== src/mrat_pkg.sv =====
// shared constants for the max rectangle above threshold block
// no dependencies
`default_nettype none
package mrat_pkg;
    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;
    localparam int ALT_BITS_DEF = 16;

    localparam int SIZE_W     = 7;
    localparam int THR_W      = 16;
    localparam int AREA_W     = 13;
    localparam int IDX_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ALTITUDE = 2'd2;

    localparam logic [SIZE_W-1:0] GRID_SIZE_RST = 7'd64;
endpackage
`default_nettype wire

// ===== src/mrat_if.sv =====
// valid/ready channel interfaces for cells, results and configuration
// depends on mrat_pkg
`default_nettype none
interface mrat_in_if #(parameter int ALT_BITS = mrat_pkg::ALT_BITS_DEF);
    logic                       valid;
    logic                       ready;
    logic signed [ALT_BITS-1:0] altitude;
    logic                       last_cell;
    modport source (output valid, altitude, last_cell, input ready);
    modport sink   (input valid, altitude, last_cell, output ready);
endinterface

interface mrat_out_if;
    logic                         valid;
    logic                         ready;
    logic [mrat_pkg::AREA_W-1:0]  best_area;
    logic [mrat_pkg::IDX_W-1:0]   top_row;
    logic [mrat_pkg::IDX_W-1:0]   left_col;
    logic [mrat_pkg::IDX_W-1:0]   bottom_row;
    logic [mrat_pkg::IDX_W-1:0]   right_col;
    logic                         found;
    modport source (output valid, best_area, top_row, left_col, bottom_row, right_col,
                    found, input ready);
    modport sink   (input valid, best_area, top_row, left_col, bottom_row, right_col,
                    found, output ready);
endinterface

interface mrat_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [mrat_pkg::CFG_IDX_W-1:0]   index;
    logic [mrat_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/max_rectangle_above_threshold_top.sv =====
// largest rectangle above threshold: top level with load, run length and search sequencer
// depends on mrat_pkg, mrat_if and mrat_ram
`default_nettype none
// Cells arrive one word per cycle in row-major order and go straight into the
// cell memory; the load side accepts a word every cycle while idle. The word
// marked last_cell starts the search, during which no cell is accepted. The
// search first sweeps each row right to left and stores the rightward run of
// qualifying cells in a second memory, through a read and a write state per
// cell. It then walks every top-left corner and extends downward row by row,
// each row step passing through a memory read, a min and multiply, and a
// compare, stopping a column early as soon as the running width drops to
// zero. The result sits in an output register, so a new load may start while
// it waits to be taken.
module max_rectangle_above_threshold_top #(
    parameter int MAX_ROWS = mrat_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = mrat_pkg::MAX_COLS_DEF,
    parameter int ALT_BITS = mrat_pkg::ALT_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    mrat_in_if.sink         i_in,
    mrat_out_if.source      o_out,
    mrat_cfg_if.sink        i_cfg
);
    localparam int RB      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CB      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW      = RB + CB;
    localparam int DEPTH   = 2 ** AW;
    localparam int RLW     = CB + 1;            // run length up to MAX_COLS
    localparam int AREA_FW = RB + CB + 2;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_RL_RD  = 7'b0000010,
        S_RL_WR  = 7'b0000100,
        S_SR_RD  = 7'b0001000,
        S_SR_MUL = 7'b0010000,
        S_SR_CMP = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [mrat_pkg::SIZE_W-1:0]    r_grid_rows, r_grid_cols;
    logic signed [mrat_pkg::THR_W-1:0] r_min_alt;

    // effective grid size: zero reads as one, oversize clamps to the maximum
    logic [8:0]     w_rows_eff, w_cols_eff;
    logic [RB-1:0]  w_last_row;
    logic [CB-1:0]  w_last_col;

    always_comb begin
        if (r_grid_rows == '0) begin
            w_rows_eff = 9'd1;
        end else if (9'(r_grid_rows) > 9'(MAX_ROWS)) begin
            w_rows_eff = 9'(MAX_ROWS);
        end else begin
            w_rows_eff = 9'(r_grid_rows);
        end
        if (r_grid_cols == '0) begin
            w_cols_eff = 9'd1;
        end else if (9'(r_grid_cols) > 9'(MAX_COLS)) begin
            w_cols_eff = 9'(MAX_COLS);
        end else begin
            w_cols_eff = 9'(r_grid_cols);
        end
    end
    assign w_last_row = RB'(w_rows_eff - 9'd1);
    assign w_last_col = CB'(w_cols_eff - 9'd1);

    // load position, row and column counters instead of a flat count
    logic [RB-1:0] r_ld_row;
    logic [CB-1:0] r_ld_col;
    logic          r_ld_full;

    logic w_in_acc, w_cfg_acc;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_in.valid & i_in.ready;
    assign w_cfg_acc   = i_cfg.valid & i_cfg.ready;

    // search position: r_r/r_c is the top-left corner (or the sweep cell), r_r2 the bottom row
    logic [RB-1:0]  r_r, r_r2;
    logic [CB-1:0]  r_c;
    logic [RLW-1:0] r_cnt;      // running count in the run length sweep
    logic [RLW-1:0] r_w;        // running min width down the column
    logic [AREA_FW-1:0] r_area;

    logic [AREA_FW-1:0] r_best_area;
    logic [RB-1:0]      r_best_top, r_best_bot;
    logic [CB-1:0]      r_best_left, r_best_right;

    // memories
    logic signed [ALT_BITS-1:0] w_cell_q;
    logic [RLW-1:0]             w_run_q;
    logic                       w_cell_we, w_run_we;
    logic [RLW-1:0]             w_cnt_n;

    assign w_cell_we = w_in_acc & ~r_ld_full;
    assign w_run_we  = (r_state == S_RL_WR);
    assign w_cnt_n   = (w_cell_q >= r_min_alt) ? r_cnt + RLW'(1) : '0;

    mrat_ram #(.WIDTH(ALT_BITS), .DEPTH(DEPTH)) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (w_cell_we),
        .i_waddr ({r_ld_row, r_ld_col}),
        .i_wdata (i_in.altitude),
        .i_raddr ({r_r, r_c}),
        .o_rdata (w_cell_q)
    );

    mrat_ram #(.WIDTH(RLW), .DEPTH(DEPTH)) u_run_ram (
        .i_clk   (i_clk),
        .i_we    (w_run_we),
        .i_waddr ({r_r, r_c}),
        .i_wdata (w_cnt_n),
        .i_raddr ({r_r2, r_c}),
        .o_rdata (w_run_q)
    );

    // width and area of the current step
    logic [RLW-1:0]  w_w_n;
    logic [RB:0]     w_height;
    logic            w_last_corner;
    logic            w_can_out;
    assign w_w_n    = (w_run_q < r_w) ? w_run_q : r_w;
    assign w_height = {1'b0, r_r2} - {1'b0, r_r} + (RB+1)'(1);
    assign w_last_corner = (r_r == w_last_row) && (r_c == w_last_col);
    assign w_can_out = ~o_out.valid | o_out.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_in_acc && i_in.last_cell) n_state = S_RL_RD;
            S_RL_RD:  n_state = S_RL_WR;
            S_RL_WR: begin
                if (r_c == '0 && r_r == w_last_row) begin
                    n_state = S_SR_RD;
                end else begin
                    n_state = S_RL_RD;
                end
            end
            S_SR_RD:  n_state = S_SR_MUL;
            S_SR_MUL: n_state = S_SR_CMP;
            S_SR_CMP: begin
                if ((r_w == '0 || r_r2 == w_last_row) && w_last_corner) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_SR_RD;
                end
            end
            S_OUT:    if (w_can_out) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_grid_rows <= mrat_pkg::GRID_SIZE_RST;
            r_grid_cols <= mrat_pkg::GRID_SIZE_RST;
            r_min_alt   <= '0;
            r_ld_row    <= '0;
            r_ld_col    <= '0;
            r_ld_full   <= 1'b0;
            r_best_area <= '0;
            o_out.valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // load counters
            if (w_cell_we) begin
                if (r_ld_col == w_last_col) begin
                    r_ld_col <= '0;
                    if (r_ld_row == w_last_row) begin
                        r_ld_full <= 1'b1;
                    end else begin
                        r_ld_row <= r_ld_row + RB'(1);
                    end
                end else begin
                    r_ld_col <= r_ld_col + CB'(1);
                end
            end
            if (w_in_acc && i_in.last_cell) begin
                r_ld_row  <= '0;
                r_ld_col  <= '0;
                r_ld_full <= 1'b0;
            end

            // configuration writes; a size write restarts the load
            if (w_cfg_acc) begin
                unique case (i_cfg.index)
                    mrat_pkg::REG_GRID_ROWS: begin
                        r_grid_rows <= i_cfg.data[mrat_pkg::SIZE_W-1:0];
                        r_ld_row <= '0;
                        r_ld_col <= '0;
                        r_ld_full <= 1'b0;
                    end
                    mrat_pkg::REG_GRID_COLS: begin
                        r_grid_cols <= i_cfg.data[mrat_pkg::SIZE_W-1:0];
                        r_ld_row <= '0;
                        r_ld_col <= '0;
                        r_ld_full <= 1'b0;
                    end
                    mrat_pkg::REG_MIN_ALTITUDE: r_min_alt <= i_cfg.data;
                    default: ;
                endcase
            end

            if (r_state == S_IDLE && w_in_acc && i_in.last_cell) begin
                r_best_area <= '0;
            end
            if (r_state == S_SR_CMP && r_w != '0 && r_area > r_best_area) begin
                r_best_area <= r_area;
            end

            // output register
            if (o_out.ready) begin
                o_out.valid <= 1'b0;
            end
            if (r_state == S_OUT && w_can_out) begin
                o_out.valid <= 1'b1;
            end
        end
    end

    // sequencer datapath, no reset needed
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                // run length sweep starts at the right end of row zero
                r_r   <= '0;
                r_c   <= w_last_col;
                r_cnt <= '0;
                r_best_top   <= '0;
                r_best_left  <= '0;
                r_best_bot   <= '0;
                r_best_right <= '0;
            end
            S_RL_RD: ;
            S_RL_WR: begin
                if (r_c == '0) begin
                    r_cnt <= '0;
                    if (r_r == w_last_row) begin
                        // hand over to the corner walk
                        r_r  <= '0;
                        r_r2 <= '0;
                        r_c  <= '0;
                        r_w  <= '1;
                    end else begin
                        r_r <= r_r + RB'(1);
                        r_c <= w_last_col;
                    end
                end else begin
                    r_cnt <= w_cnt_n;
                    r_c   <= r_c - CB'(1);
                end
            end
            S_SR_RD: ;
            S_SR_MUL: begin
                r_w    <= w_w_n;
                r_area <= AREA_FW'(w_height) * AREA_FW'(w_w_n);
            end
            S_SR_CMP: begin
                if (r_w != '0 && r_area > r_best_area) begin
                    r_best_top   <= r_r;
                    r_best_left  <= r_c;
                    r_best_bot   <= r_r2;
                    r_best_right <= CB'({1'b0, r_c} + r_w - RLW'(1));
                end
                if (r_w == '0 || r_r2 == w_last_row) begin
                    // next top-left corner
                    r_w <= '1;
                    if (r_c == w_last_col) begin
                        r_c  <= '0;
                        r_r  <= r_r + RB'(1);
                        r_r2 <= r_r + RB'(1);
                    end else begin
                        r_c  <= r_c + CB'(1);
                        r_r2 <= r_r;
                    end
                end else begin
                    r_r2 <= r_r2 + RB'(1);
                end
            end
            S_OUT: begin
                if (w_can_out) begin
                    o_out.best_area  <= mrat_pkg::AREA_W'(r_best_area);
                    o_out.top_row    <= mrat_pkg::IDX_W'(r_best_top);
                    o_out.left_col   <= mrat_pkg::IDX_W'(r_best_left);
                    o_out.bottom_row <= mrat_pkg::IDX_W'(r_best_bot);
                    o_out.right_col  <= mrat_pkg::IDX_W'(r_best_right);
                    o_out.found      <= (r_best_area != '0);
                end
            end
            default: ;
        endcase
    end

    // the bottom row never sits above the top row while comparing
    a_rows_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SR_CMP) |-> (r_r2 >= r_r))
        else $error("bottom row above top row");

    // a freshly loaded result has found set exactly when the area is nonzero
    a_found_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state == S_OUT) && $past(w_can_out)) |->
        (o_out.found == (o_out.best_area != '0)))
        else $error("found flag disagrees with area");

    // best area never grows past the grid
    a_area_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |->
        (32'(r_best_area) <= 32'(w_rows_eff) * 32'(w_cols_eff)))
        else $error("best area exceeds grid");
endmodule
`default_nettype wire

// ===== src/mrat_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module mrat_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [AW-1:0]         i_waddr,
    input  wire logic [WIDTH-1:0]      i_wdata,
    input  wire logic [AW-1:0]         i_raddr,
    output logic      [WIDTH-1:0]      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
